// ----- hdl/lscf_pkg.sv -----
// Shared types, constants and helpers for the LED segment CAN framer.
package lscf_pkg;

    // Panel geometry: segments per panel row
    localparam int SEGMENTS_ACROSS = 3;

    // Segment store geometry
    localparam int ROW_W     = 32;
    localparam int ROW_COUNT = 16;
    localparam int ROW_IDX_W = $clog2(ROW_COUNT);
    localparam logic [ROW_IDX_W-1:0] ROW_LAST = ROW_IDX_W'(ROW_COUNT - 1);

    // Command queue depth between front and back
    localparam int CMD_QUEUE_DEPTH = 2;

    // Stream widths
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 104;

    // CAN identifier parts
    localparam int CAN_ID_W = 29;
    localparam logic [CAN_ID_W-1:0] ID_BASE     = 29'h1F0E1FFF;
    localparam logic [CAN_ID_W-1:0] CMD_HEADER  = 29'h00B00000;
    localparam logic [CAN_ID_W-1:0] CMD_DATA    = 29'h00900000;
    localparam logic [CAN_ID_W-1:0] CMD_TRAILER = 29'h00700000;

    // Message lengths
    localparam logic [3:0] BYTES_FULL    = 4'd8;
    localparam logic [3:0] BYTES_TRAILER = 4'd2;

    // Fixed payloads
    localparam logic [63:0] HDR_FIXED    = 64'hF77FFFFFFDFF0000;
    localparam logic [63:0] TRAILER_WORD = 64'h0000000000007FFF;
    localparam logic [63:0] CLR_FIRST    = 64'h0101010101010100;
    localparam logic [63:0] CLR_REST     = 64'h0101010101010101;

    // Data messages per segment, indexed 2g+h
    localparam logic [2:0] MSG_LAST  = 3'd7;
    localparam logic [2:0] BYTE_LAST = 3'd7;

    // One classified job handed from front to back
    typedef struct packed {
        logic                is_clear;
        logic [CAN_ID_W-1:0] id_base;
        logic [7:0]          frame_slot;
    } cmd_t;

    // Regroup one pixel row into a payload byte for bit pair g
    function automatic logic [7:0] encode_row(logic [ROW_W-1:0] row, logic [1:0] g);
        logic [7:0] v;
        int         base;
        v = '0;
        for (int k = 0; k < 4; k++) begin
            base     = 8 * k + 2 * int'(g);
            v[4 + k] = row[base + 1];
            v[k]     = row[base];
        end
        return v;
    endfunction

endpackage

// ----- hdl/led_segment_can_framer_unit.sv -----
// Top level of the LED segment CAN framer.
// Pixel rows are taken one beat per cycle while s_axis_tready is high and
// written into a 16-entry row store; the sixteenth row of a segment, or a
// clear request, queues a job for the message sequencer. A segment job sends
// a header, eight data messages and a trailer; each data message gathers
// eight rows through the single read port of the row store, one row at a
// time, and new beats wait until the trailer of that segment is sent. A
// clear job sends its ten fixed messages and does not hold new beats, and up
// to QUEUE_DEPTH jobs may wait.
module led_segment_can_framer_unit
    import lscf_pkg::*;
#(
    parameter int QUEUE_DEPTH = CMD_QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // row_word[31:0], seg_x[33:32], seg_y[35:34], frame_slot[43:36], zero pad
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // func[0]: 0 pixel row, 1 clear request
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // can_id[28:0], byte_count[32:29], payload[96:33], zero pad
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tlast
);

    logic                 q_full, q_empty, q_push, q_pop;
    cmd_t                 push_cmd, pop_cmd;
    logic                 seg_done;
    logic [ROW_IDX_W-1:0] rd_addr;
    logic [ROW_W-1:0]     rd_data;
    logic [CAN_ID_W-1:0]  can_id;
    logic [3:0]           byte_count;
    logic [63:0]          payload;

    lscf_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (push_cmd),
        .seg_done      (seg_done),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data)
    );

    lscf_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    lscf_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_cmd        (pop_cmd),
        .q_pop        (q_pop),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .seg_done     (seg_done),
        .m_valid      (m_axis_tvalid),
        .m_ready      (m_axis_tready),
        .m_can_id     (can_id),
        .m_byte_count (byte_count),
        .m_payload    (payload),
        .m_last       (m_axis_tlast)
    );

    // Pack the result beat
    assign m_axis_tdata = {7'b0, payload, byte_count, can_id};

endmodule

// ----- hdl/lscf_front.sv -----
// Front end: accepts beats, stores pixel rows and queues emit jobs.
module lscf_front
    import lscf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tuser,
    input  logic                 q_full,
    output logic                 q_push,
    output cmd_t                 q_cmd,
    input  logic                 seg_done,
    input  logic [ROW_IDX_W-1:0] rd_addr,
    output logic [ROW_W-1:0]     rd_data
);

    logic [ROW_W-1:0]     row_mem [ROW_COUNT];
    logic [ROW_W-1:0]     rd_data_reg;
    logic [ROW_IDX_W-1:0] rows_loaded_reg, rows_loaded_next;
    logic                 lock_reg, lock_next;
    logic                 accept;
    logic                 func;
    logic [ROW_W-1:0]     row_word;
    logic [1:0]           seg_x, seg_y;
    logic [7:0]           frame_slot;
    logic [3:0]           panel_id;

    // Unpack the beat
    assign func       = s_axis_tuser;
    assign row_word   = s_axis_tdata[31:0];
    assign seg_x      = s_axis_tdata[33:32];
    assign seg_y      = s_axis_tdata[35:34];
    assign frame_slot = s_axis_tdata[43:36];

    // Hold input while the job queue is full or the back end still reads a full segment
    assign s_axis_tready = !q_full && !lock_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Panel id and base identifier, cut to four bits
    assign panel_id = {2'b00, seg_y} * 4'(SEGMENTS_ACROSS) + {2'b00, seg_x} + 4'd1;

    assign q_cmd.is_clear   = func;
    assign q_cmd.id_base    = ID_BASE | {12'b0, ~panel_id, 13'b0};
    assign q_cmd.frame_slot = frame_slot;

    // Count rows and queue a job on a clear or on the sixteenth row
    always_comb begin
        rows_loaded_next = rows_loaded_reg;
        lock_next        = lock_reg;
        q_push           = 1'b0;
        if (seg_done) begin
            lock_next = 1'b0;
        end
        if (accept) begin
            if (func) begin
                rows_loaded_next = '0;
                q_push           = 1'b1;
            end else if (rows_loaded_reg == ROW_LAST) begin
                rows_loaded_next = '0;
                q_push           = 1'b1;
                lock_next        = 1'b1;
            end else begin
                rows_loaded_next = rows_loaded_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_loaded_reg <= '0;
            lock_reg        <= 1'b0;
        end else begin
            rows_loaded_reg <= rows_loaded_next;
            lock_reg        <= lock_next;
        end
    end

    // Row store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (accept && !func) begin
            row_mem[rows_loaded_reg] <= row_word;
        end
        rd_data_reg <= row_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/lscf_cmd_queue.sv -----
// Short job queue between the front end and the back end.
module lscf_cmd_queue
    import lscf_pkg::*;
#(
    parameter int DEPTH = CMD_QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- hdl/lscf_back.sv -----
// Back end: sequences the ten CAN messages of each job into the output register.
module lscf_back
    import lscf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_empty,
    input  cmd_t                 q_cmd,
    output logic                 q_pop,
    output logic [ROW_IDX_W-1:0] rd_addr,
    input  logic [ROW_W-1:0]     rd_data,
    output logic                 seg_done,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CAN_ID_W-1:0]  m_can_id,
    output logic [3:0]           m_byte_count,
    output logic [63:0]          m_payload,
    output logic                 m_last
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_HDR  = 7'b0000010,
        ST_READ = 7'b0000100,
        ST_GATH = 7'b0001000,
        ST_DATA = 7'b0010000,
        ST_CLR  = 7'b0100000,
        ST_TRL  = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [2:0]          msg_reg, msg_next;
    logic [2:0]          byte_reg, byte_next;
    logic [63:0]         acc_reg, acc_next;
    logic                out_valid_reg, out_valid_next;
    logic [CAN_ID_W-1:0] out_id_reg, out_id_next;
    logic [3:0]          out_count_reg, out_count_next;
    logic [63:0]         out_payload_reg, out_payload_next;
    logic                out_last_reg, out_last_next;
    logic                slot_free;

    // The output register takes a new beat when empty or being drained
    assign slot_free = !out_valid_reg || m_ready;

    // Row order: byte b of half h reads row 15-8h-b
    assign rd_addr = {~msg_reg[0], ~byte_reg};

    always_comb begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        msg_next         = msg_reg;
        byte_next        = byte_reg;
        acc_next         = acc_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        out_id_next      = out_id_reg;
        out_count_next   = out_count_reg;
        out_payload_next = out_payload_reg;
        out_last_next    = out_last_reg;
        q_pop            = 1'b0;
        seg_done         = 1'b0;
        case (state_reg)
            // Take the next job
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    msg_next   = '0;
                    byte_next  = '0;
                    state_next = ST_HDR;
                end
            end
            // Emit the header
            ST_HDR: begin
                if (slot_free) begin
                    out_valid_next   = 1'b1;
                    out_id_next      = cmd_reg.id_base | CMD_HEADER;
                    out_count_next   = BYTES_FULL;
                    out_payload_next = HDR_FIXED |
                        {56'b0, cmd_reg.is_clear ? 8'h00 : cmd_reg.frame_slot};
                    out_last_next    = 1'b0;
                    state_next       = cmd_reg.is_clear ? ST_CLR : ST_READ;
                end
            end
            // Row address is presented; data arrives next cycle
            ST_READ: begin
                state_next = ST_GATH;
            end
            // Pack one regrouped byte
            ST_GATH: begin
                acc_next[8*byte_reg +: 8] = encode_row(rd_data, msg_reg[2:1]);
                if (byte_reg == BYTE_LAST) begin
                    state_next = ST_DATA;
                end else begin
                    byte_next  = byte_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            // Emit one data payload
            ST_DATA: begin
                if (slot_free) begin
                    out_valid_next   = 1'b1;
                    out_id_next      = cmd_reg.id_base | CMD_DATA;
                    out_count_next   = BYTES_FULL;
                    out_payload_next = acc_reg;
                    out_last_next    = 1'b0;
                    byte_next        = '0;
                    if (msg_reg == MSG_LAST) begin
                        state_next = ST_TRL;
                    end else begin
                        msg_next   = msg_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            // Emit one fixed clear payload
            ST_CLR: begin
                if (slot_free) begin
                    out_valid_next   = 1'b1;
                    out_id_next      = cmd_reg.id_base | CMD_DATA;
                    out_count_next   = BYTES_FULL;
                    out_payload_next = (msg_reg == '0) ? CLR_FIRST : CLR_REST;
                    out_last_next    = 1'b0;
                    if (msg_reg == MSG_LAST) begin
                        state_next = ST_TRL;
                    end else begin
                        msg_next = msg_reg + 1'b1;
                    end
                end
            end
            // Emit the trailer and release the row store
            ST_TRL: begin
                if (slot_free) begin
                    out_valid_next   = 1'b1;
                    out_id_next      = cmd_reg.id_base | CMD_TRAILER;
                    out_count_next   = BYTES_TRAILER;
                    out_payload_next = TRAILER_WORD;
                    out_last_next    = 1'b1;
                    seg_done         = !cmd_reg.is_clear;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg         <= cmd_next;
        msg_reg         <= msg_next;
        byte_reg        <= byte_next;
        acc_reg         <= acc_next;
        out_id_reg      <= out_id_next;
        out_count_reg   <= out_count_next;
        out_payload_reg <= out_payload_next;
        out_last_reg    <= out_last_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_can_id     = out_id_reg;
    assign m_byte_count = out_count_reg;
    assign m_payload    = out_payload_reg;
    assign m_last       = out_last_reg;

    // Read data is only packed in the cycle after its address was set up
    a_gath_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_GATH) |-> ($past(state_reg) == ST_READ))
        else $error("byte packed without a preceding row read");

    // Only the trailer is short and marked last
    a_last_short: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_last_reg) |-> (out_count_reg == BYTES_FULL))
        else $error("non-trailer message with short length");

    // The trailer follows all eight data payloads
    a_trl_after_eight: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TRL) |-> (msg_reg == MSG_LAST))
        else $error("trailer reached before eight data payloads");

endmodule
